[rtl/bte_pkg.sv]
// box target encoder: shared types, constants and helpers
// no dependencies; imported by box_target_encoder_top, bte_cfg, bte_seq and bte_dp
`default_nettype none
package bte_pkg;

	localparam int ONE_Q15     = 32768;
	localparam int HEAD_VALUES = 5;

	localparam int DEF_MAX_ANCHORS = 4;
	localparam int DEF_MAX_GRID    = 32;
	localparam int DEF_MAX_CLASSES = 255;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_CELLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS_LO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS_HI   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XS,
		ST_YS,
		ST_WH,
		ST_CELL,
		ST_INTER,
		ST_AREA,
		ST_CROSS1,
		ST_CROSS2,
		ST_CMP,
		ST_CHAN,
		ST_BASE,
		ST_BOFF,
		ST_OUT
	} state_t;

	// clamped configuration as seen by the datapath and sequencer
	typedef struct packed {
		logic [5:0]  grid;
		logic [2:0]  anchors_n;
		logic [7:0]  classes;
		logic [63:0] pair_lo;
		logic [63:0] pair_hi;
	} cfg_t;

	typedef struct packed {
		state_t     step;
		logic [1:0] anchor;
		logic       load;
	} ctrl_t;

	typedef struct packed {
		logic class_ok;
	} stat_t;

	function automatic logic [15:0] sat_one(input logic [15:0] v);
		logic [15:0] r;
		r = (v > 16'(ONE_Q15)) ? 16'(ONE_Q15) : v;
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/box_target_encoder_top.sv]
// box target encoder top level: config registers, sequencer and datapath
// depends on bte_pkg, bte_cfg, bte_seq, bte_dp
//
// usage
//   a labelled box (class, centre x/y, width, height in q1.15) is taken when
//   start is high and busy is low. the block then works on that box alone
//   with one shared 32x32 multiplier, one product per cycle, and raises done
//   for exactly one cycle with the result on the output ports. that cycle is
//   the result beat; the receiver cannot stall it and must take it then.
//   a box with a valid class keeps the block busy for four setup products,
//   five steps per anchor in use for the iou cross-multiply compare, three
//   for the entry index and one to load the result registers. done shows
//   in the cycle after busy falls, and a new box may start in that very
//   cycle. a box with a class out of range skips the arithmetic and goes
//   straight to loading the result registers.
//   configuration beats go to their own channel; cfg_ready is low while busy
//   or while start is high, so registers only change between boxes.
//   reset clears the sequencer and loads the register defaults: 13 cells,
//   one anchor, one class, all anchor sizes zero.
`default_nettype none
module box_target_encoder_top
	import bte_pkg::*;
#(
	parameter int MAX_ANCHORS = DEF_MAX_ANCHORS,
	parameter int MAX_GRID    = DEF_MAX_GRID,
	parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// box channel
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [8:0]           class_index,
	input  wire logic [15:0]          centre_x,
	input  wire logic [15:0]          centre_y,
	input  wire logic [15:0]          box_width,
	input  wire logic [15:0]          box_height,
	// result channel
	output logic                      done,
	output logic                      valid_res,
	output logic [4:0]                cell_row,
	output logic [4:0]                cell_col,
	output logic [1:0]                anchor_index,
	output logic [20:0]               entry_base,
	output logic [15:0]               frac_x,
	output logic [15:0]               frac_y,
	output logic [15:0]               out_width,
	output logic [15:0]               out_height,
	output logic [7:0]                class_slot,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;

	// registers never change under a box in flight or a box being taken
	assign cfg_ready = !busy && !start;

	bte_cfg #(
		.MAX_ANCHORS (MAX_ANCHORS),
		.MAX_GRID    (MAX_GRID),
		.MAX_CLASSES (MAX_CLASSES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: at most one multiplier step per state, anchors walked in order
	bte_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg    (cfg),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	// datapath: latched box, shared multiplier, iou best tracking, result registers
	bte_dp u_dp (
		.clk          (clk),
		.ctrl         (ctrl),
		.cfg          (cfg),
		.class_index  (class_index),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.stat         (stat),
		.valid_res    (valid_res),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.anchor_index (anchor_index),
		.entry_base   (entry_base),
		.frac_x       (frac_x),
		.frac_y       (frac_y),
		.out_width    (out_width),
		.out_height   (out_height),
		.class_slot   (class_slot)
	);

endmodule
`default_nettype wire

[rtl/bte_cfg.sv]
// box target encoder: configuration registers and range clamping
// depends on bte_pkg
`default_nettype none
module bte_cfg
	import bte_pkg::*;
#(
	parameter int MAX_ANCHORS = DEF_MAX_ANCHORS,
	parameter int MAX_GRID    = DEF_MAX_GRID,
	parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	output cfg_t                      cfg
);

	localparam int ALIM = (MAX_ANCHORS < 4) ? MAX_ANCHORS : 4;

	logic [5:0]  grid_q;
	logic [2:0]  acount_q;
	logic [7:0]  ccount_q;
	logic [63:0] pair_lo_q;
	logic [63:0] pair_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q    <= 6'd13;
			acount_q  <= 3'd1;
			ccount_q  <= 8'd1;
			pair_lo_q <= '0;
			pair_hi_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_CELLS:   grid_q    <= cfg_data[5:0];
				CFG_ANCHOR_COUNT: acount_q  <= cfg_data[2:0];
				CFG_CLASS_COUNT:  ccount_q  <= cfg_data[7:0];
				CFG_ANCHORS_LO:   pair_lo_q <= cfg_data;
				CFG_ANCHORS_HI:   pair_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_q == '0)
			cfg.grid = 6'd1;
		else if (32'(grid_q) > MAX_GRID)
			cfg.grid = 6'(MAX_GRID);
		else
			cfg.grid = grid_q;

		if (acount_q == '0)
			cfg.anchors_n = 3'd1;
		else if (32'(acount_q) > ALIM)
			cfg.anchors_n = 3'(ALIM);
		else
			cfg.anchors_n = acount_q;

		if (ccount_q == '0)
			cfg.classes = 8'd1;
		else if (32'(ccount_q) > MAX_CLASSES)
			cfg.classes = 8'(MAX_CLASSES);
		else
			cfg.classes = ccount_q;

		cfg.pair_lo = pair_lo_q;
		cfg.pair_hi = pair_hi_q;
	end

endmodule
`default_nettype wire

[rtl/bte_seq.sv]
// box target encoder: step sequencer driving the shared multiplier
// depends on bte_pkg
`default_nettype none
module bte_seq
	import bte_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire cfg_t  cfg,
	input  wire stat_t stat,
	output ctrl_t      ctrl,
	output logic       busy,
	output logic       done
);

	state_t     state_q, state_d;
	logic [1:0] anchor_q, anchor_d;
	logic       done_q;
	logic       last_anchor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			anchor_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			anchor_q <= anchor_d;
			done_q   <= (state_q == ST_OUT);
		end
	end

	assign last_anchor = ({1'b0, anchor_q} == (cfg.anchors_n - 3'd1));

	always_comb begin
		state_d  = state_q;
		anchor_d = anchor_q;
		case (state_q)
			ST_IDLE: begin
				anchor_d = '0;
				if (start)
					state_d = stat.class_ok ? ST_XS : ST_OUT;
			end
			ST_XS:     state_d = ST_YS;
			ST_YS:     state_d = ST_WH;
			ST_WH:     state_d = ST_CELL;
			ST_CELL:   state_d = ST_INTER;
			ST_INTER:  state_d = ST_AREA;
			ST_AREA:   state_d = ST_CROSS1;
			ST_CROSS1: state_d = ST_CROSS2;
			ST_CROSS2: state_d = ST_CMP;
			ST_CMP: begin
				if (last_anchor) begin
					state_d = ST_CHAN;
				end else begin
					anchor_d = anchor_q + 2'd1;
					state_d  = ST_INTER;
				end
			end
			ST_CHAN:   state_d = ST_BASE;
			ST_BASE:   state_d = ST_BOFF;
			ST_BOFF:   state_d = ST_OUT;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign ctrl.step   = state_q;
	assign ctrl.anchor = anchor_q;
	assign ctrl.load   = (state_q == ST_IDLE) && start;
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;

endmodule
`default_nettype wire

[rtl/bte_dp.sv]
// box target encoder: working registers around one shared 32x32 multiplier
// depends on bte_pkg; steered by bte_seq
`default_nettype none
module bte_dp
	import bte_pkg::*;
(
	input  wire logic        clk,
	input  wire ctrl_t       ctrl,
	input  wire cfg_t        cfg,
	input  wire logic [8:0]  class_index,
	input  wire logic [15:0] centre_x,
	input  wire logic [15:0] centre_y,
	input  wire logic [15:0] box_width,
	input  wire logic [15:0] box_height,
	output stat_t            stat,
	output logic             valid_res,
	output logic [4:0]       cell_row,
	output logic [4:0]       cell_col,
	output logic [1:0]       anchor_index,
	output logic [20:0]      entry_base,
	output logic [15:0]      frac_x,
	output logic [15:0]      frac_y,
	output logic [15:0]      out_width,
	output logic [15:0]      out_height,
	output logic [7:0]       class_slot
);

	logic [15:0] x_q, y_q, w_q, h_q;
	logic [7:0]  cls_q;
	logic        ok_q;
	logic [20:0] xs_q, ys_q;
	logic [5:0]  col_q, row_q;
	logic [30:0] wh_q, inter_q, area_q, bi_q;
	logic [31:0] uni_q, bu_q;
	logic [61:0] c1_q, c2_q;
	logic [11:0] cell_q;
	logic [10:0] chan_q;
	logic [22:0] base_q;
	logic [10:0] boff_q;
	logic [1:0]  best_q;

	logic [MUL_W-1:0]  opa, opb;
	logic [PROD_W-1:0] prod;
	logic [63:0]       pair;
	logic [31:0]       half;
	logic [15:0]       aw, ah, mw, mh;
	logic [5:0]        gm1, xcell, ycell;
	logic [8:0]        per_box;
	logic [31:0]       uni_sum;
	logic [22:0]       base_sum;
	logic [20:0]       offx_full, offy_full;

	assign stat.class_ok = !class_index[8] && (class_index[7:0] < cfg.classes);

	// current anchor size, saturated
	assign pair = ctrl.anchor[1] ? cfg.pair_hi : cfg.pair_lo;
	assign half = ctrl.anchor[0] ? pair[63:32] : pair[31:0];
	assign aw   = sat_one(half[15:0]);
	assign ah   = sat_one(half[31:16]);
	assign mw   = (w_q < aw) ? w_q : aw;
	assign mh   = (h_q < ah) ? h_q : ah;

	assign gm1     = cfg.grid - 6'd1;
	assign xcell   = (xs_q[20:15] > gm1) ? gm1 : xs_q[20:15];
	assign ycell   = (ys_q[20:15] > gm1) ? gm1 : ys_q[20:15];
	assign per_box = 9'(HEAD_VALUES) + {1'b0, cfg.classes};
	assign uni_sum = {1'b0, wh_q} + {1'b0, area_q} - {1'b0, inter_q};

	// operand selection for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (ctrl.step)
			ST_XS:     begin opa = MUL_W'(x_q);     opb = MUL_W'(cfg.grid); end
			ST_YS:     begin opa = MUL_W'(y_q);     opb = MUL_W'(cfg.grid); end
			ST_WH:     begin opa = MUL_W'(w_q);     opb = MUL_W'(h_q); end
			ST_CELL:   begin opa = MUL_W'(row_q);   opb = MUL_W'(cfg.grid); end
			ST_INTER:  begin opa = MUL_W'(mw);      opb = MUL_W'(mh); end
			ST_AREA:   begin opa = MUL_W'(aw);      opb = MUL_W'(ah); end
			ST_CROSS1: begin opa = MUL_W'(inter_q); opb = bu_q; end
			ST_CROSS2: begin opa = MUL_W'(bi_q);    opb = uni_q; end
			ST_CHAN:   begin opa = MUL_W'(cfg.anchors_n); opb = MUL_W'(per_box); end
			ST_BASE:   begin opa = MUL_W'(cell_q);  opb = MUL_W'(chan_q); end
			ST_BOFF:   begin opa = MUL_W'(best_q);  opb = MUL_W'(per_box); end
			default:   begin opa = '0;              opb = '0; end
		endcase
	end

	assign prod = PROD_W'(opa) * PROD_W'(opb);

	assign base_sum  = base_q + 23'(boff_q);
	assign offx_full = xs_q - {col_q, 15'd0};
	assign offy_full = ys_q - {row_q, 15'd0};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q   <= sat_one(centre_x);
			y_q   <= sat_one(centre_y);
			w_q   <= sat_one(box_width);
			h_q   <= sat_one(box_height);
			cls_q <= class_index[7:0];
			ok_q  <= stat.class_ok;
		end
		case (ctrl.step)
			ST_XS:   xs_q <= prod[20:0];
			ST_YS: begin
				ys_q  <= prod[20:0];
				col_q <= xcell;
			end
			ST_WH: begin
				wh_q  <= prod[30:0];
				row_q <= ycell;
			end
			ST_CELL:  cell_q  <= prod[11:0] + 12'(col_q);
			ST_INTER: inter_q <= prod[30:0];
			ST_AREA:  area_q  <= prod[30:0];
			ST_CROSS1: begin
				c1_q  <= prod[61:0];
				// zero union counts as zero iou; intersection is already zero then
				uni_q <= (uni_sum == '0) ? 32'd1 : uni_sum;
			end
			ST_CROSS2: c2_q <= prod[61:0];
			ST_CMP: begin
				if (ctrl.anchor == 2'd0 || c1_q > c2_q) begin
					bi_q   <= inter_q;
					bu_q   <= uni_q;
					best_q <= ctrl.anchor;
				end
			end
			ST_CHAN: chan_q <= prod[10:0];
			ST_BASE: base_q <= prod[22:0];
			ST_BOFF: boff_q <= prod[10:0];
			ST_OUT: begin
				valid_res <= ok_q;
				if (ok_q) begin
					cell_row     <= row_q[4:0];
					cell_col     <= col_q[4:0];
					anchor_index <= best_q;
					entry_base   <= base_sum[20:0];
					frac_x       <= offx_full[15:0];
					frac_y       <= offy_full[15:0];
					out_width    <= w_q;
					out_height   <= h_q;
					class_slot   <= cls_q;
				end else begin
					cell_row     <= '0;
					cell_col     <= '0;
					anchor_index <= '0;
					entry_base   <= '0;
					frac_x       <= '0;
					frac_y       <= '0;
					out_width    <= '0;
					out_height   <= '0;
					class_slot   <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/bte_checker.sv]
// box target encoder: port-level checker and its bind to the top level
// depends on box_target_encoder_top
`default_nettype none
module bte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        valid_res,
	input wire logic [4:0]  cell_row,
	input wire logic [4:0]  cell_col,
	input wire logic [1:0]  anchor_index,
	input wire logic [20:0] entry_base,
	input wire logic [7:0]  class_slot
);

	// result beat only once the box is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// result beat comes straight after a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding work");

	// one beat per box
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted box always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted box did not raise busy");

	// rejected class gives zero cell, anchor, entry base and class slot
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (cell_row == '0 && cell_col == '0 &&
			anchor_index == '0 && entry_base == '0 && class_slot == '0))
		else $error("rejected box with nonzero fields");

endmodule

bind box_target_encoder_top bte_checker u_bte_checker (.*);
`default_nettype wire
